@@ hdl/wsea_pkg.sv @@
// ----------------------------------------------------------------------------
// wsea_pkg: shared types and constants for the weighted squared error block
// Field widths, register codes, sequencer states and the 2^x lookup table.
// ----------------------------------------------------------------------------
package wsea_pkg;

  // Field and register widths
  localparam int MAX_W      = 31;
  localparam int K_W        = 16;
  localparam int E_W        = 32;
  localparam int G_W        = 16;
  localparam int SUM_W      = 63;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;

  // Register codes
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEVEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_GAIN   = 1'd1;

  localparam logic [MAX_W-1:0] CLIP_LEVEL_RESET = 31'd65536;
  localparam logic [K_W-1:0]   EXP_GAIN_RESET   = 16'd768;

  // Datapath widths
  localparam int MUL_W   = 32;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int Q_W     = 22;              // exponent magnitude, Q.16, clamp 32.0
  localparam int NUM_W   = 56;              // |k| * d * 256
  localparam int CNT_W   = $clog2(Q_W);
  localparam int PF_W    = 33;              // 2^t in Q2.31 reaches 2.0
  localparam int N_EXP_W = 7;
  localparam int ACC_W   = 112;

  localparam logic [Q_W-1:0]   EXP_CLAMP = 22'h20_0000;
  localparam logic [16:0]      LOG2E_Q16 = 17'd94548;
  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

  // Power-of-two table
  localparam int EXP_TABLE_ENTRIES = 64;
  localparam int TAB_AW = $clog2(EXP_TABLE_ENTRIES + 1);

  localparam logic [63:0] LN2_Q31 = 64'd1488522236;
  localparam logic [63:0] ONE_Q31 = 64'h8000_0000;

  typedef logic [PF_W-1:0] pow2_tab_t [0:EXP_TABLE_ENTRIES];

  // Build 2^(j/N) in Q2.31 by a truncated Taylor series of exp(j*ln2/N)
  function automatic pow2_tab_t build_pow2_tab();
    pow2_tab_t   tab;
    logic [63:0] u;
    logic [63:0] sum;
    logic [63:0] term;
    for (int j = 0; j <= EXP_TABLE_ENTRIES; j++) begin
      u    = (64'(j) * LN2_Q31) / EXP_TABLE_ENTRIES;
      sum  = ONE_Q31;
      term = ONE_Q31;
      for (int k = 1; k <= 20; k++) begin
        term = ((term * u) >> 31) / 64'(k);
        sum  = sum + term;
      end
      tab[j] = sum[PF_W-1:0];
    end
    return tab;
  endfunction

  localparam pow2_tab_t POW2_TAB = build_pow2_tab();

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE, ST_MAG, ST_NUM, ST_DIV, ST_LOG, ST_FRAC, ST_TMUL, ST_IDX,
    ST_SPAN, ST_POW, ST_SQ, ST_GW, ST_GWL, ST_PPI, ST_PPA, ST_ACC
  } state_t;

  // Divider status
  typedef struct packed {
    logic done;
    logic ovf;
  } div_status_t;

endpackage

@@ hdl/wsea_if.sv @@
// ----------------------------------------------------------------------------
// wsea_if: point and result channels
// Valid/ready channels carrying one point beat in and one total beat out.
// ----------------------------------------------------------------------------
interface wsea_in_if;
  logic                     valid;
  logic                     ready;
  logic [wsea_pkg::E_W-1:0] reference_energy;
  logic [wsea_pkg::E_W-1:0] fitted_energy;
  logic [wsea_pkg::G_W-1:0] curve_gain;
  logic                     last_point;

  modport source (output valid, reference_energy, fitted_energy, curve_gain, last_point,
                  input ready);
  modport sink   (input valid, reference_energy, fitted_energy, curve_gain, last_point,
                  output ready);
endinterface

interface wsea_out_if;
  logic                       valid;
  logic                       ready;
  logic [wsea_pkg::SUM_W-1:0] total_error;
  logic                       saturated;

  modport source (output valid, total_error, saturated, input ready);
  modport sink   (input valid, total_error, saturated, output ready);
endinterface

@@ hdl/weighted_sq_error_accumulator.sv @@
// ----------------------------------------------------------------------------
// weighted_sq_error_accumulator: exponentially weighted sum of squared errors
// Clips both energies, forms exp(k*(M-ref)/M) from a 2^x table, and adds
// gain * factor (Q16.16) * (ref-fit)^2 to a saturating 63-bit total.
//
//   channel  dir  beat contents
//   in_ch    in   reference_energy, fitted_energy, curve_gain, last_point
//   out_ch   out  total_error, saturated (one beat per last point)
//   cfg_*    in   clip level (index 0), exponent gain (index 1)
//
// A new point is accepted only from idle, after the last one is done; the
// wait on the 22-step exponent divider ends without those steps when the
// quotient would not fit in the divider's width.
// All products run through one 32x32 multiplier. Reset is synchronous; it
// restores both registers and clears the total. A last point waits in its
// final step, adding cycles, while the result register holds an untaken beat.
// ----------------------------------------------------------------------------
module weighted_sq_error_accumulator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [wsea_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wsea_pkg::CFG_DATA_W-1:0]     cfg_data,
  wsea_in_if.sink                             in_ch,
  wsea_out_if.source                          out_ch
);

  wsea_pkg::state_t                 state_r, state_nxt;

  logic [wsea_pkg::MAX_W-1:0]       clip_level_r;
  logic [wsea_pkg::K_W-1:0]         exp_gain_r;
  logic [wsea_pkg::SUM_W-1:0]       error_sum_r;
  logic                             overflow_r;

  logic [31:0]                      d_r;
  logic [31:0]                      ad_r;
  logic [wsea_pkg::G_W-1:0]         gain_r;
  logic                             last_r;
  logic [wsea_pkg::Q_W-1:0]         e_r;
  logic [wsea_pkg::N_EXP_W-1:0]     n_r;
  logic                             tz_r;
  logic [31:0]                      targ_r;
  logic [wsea_pkg::PF_W-1:0]        lo_r;
  logic [31:0]                      span_r;
  logic [31:0]                      rem_r;
  logic [31:0]                      w_r;
  logic                             sat_pt_r;
  logic [63:0]                      sq_r;
  logic [47:0]                      gw_r;
  logic [1:0]                       pp_cnt_r;
  logic [wsea_pkg::ACC_W-1:0]       acc_r;

  logic                             out_valid_r;
  logic [wsea_pkg::SUM_W-1:0]       out_total_r;
  logic                             out_sat_r;

  logic [wsea_pkg::MUL_W-1:0]       mul_a, mul_b;
  logic [wsea_pkg::PROD_W-1:0]      prod;
  logic                             div_start;
  wsea_pkg::div_status_t            div_st;
  logic [wsea_pkg::Q_W-1:0]         div_q;
  logic                             in_ready;

  // Register shorthands
  logic                             k_neg;
  logic [wsea_pkg::K_W-1:0]         k_mag;
  logic [wsea_pkg::MAX_W-1:0]       den;
  logic signed [31:0]               m_s, r_s, f_s, a_s, b_s;
  logic signed [32:0]               d33, diff33, ad33;

  always_comb begin
    k_neg  = exp_gain_r[wsea_pkg::K_W-1];
    k_mag  = k_neg ? (~exp_gain_r + 1'b1) : exp_gain_r;
    den    = (clip_level_r == '0) ? wsea_pkg::MAX_W'(1) : clip_level_r;
    m_s    = signed'({1'b0, clip_level_r});
    r_s    = signed'(in_ch.reference_energy);
    f_s    = signed'(in_ch.fitted_energy);
    a_s    = (r_s < m_s) ? r_s : m_s;
    b_s    = (f_s < m_s) ? f_s : m_s;
    d33    = {m_s[31], m_s} - {a_s[31], a_s};
    diff33 = {a_s[31], a_s} - {b_s[31], b_s};
    ad33   = diff33[32] ? -diff33 : diff33;
  end

  // Shared units
  wsea_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  wsea_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    ({prod[47:0], 8'd0}),
    .den    (den),
    .status (div_st),
    .quot   (div_q)
  );

  // Table lookup, factor and total arithmetic
  logic [wsea_pkg::TAB_AW-1:0]      idx;
  logic [wsea_pkg::PF_W-1:0]        tab_lo, tab_hi, pf;
  logic [wsea_pkg::PF_W+14:0]       pos_shl;
  logic [wsea_pkg::PF_W-1:0]        pos_val, neg_src, neg_val;
  logic                             pos_sat;
  logic [wsea_pkg::N_EXP_W-1:0]     neg_sh;
  logic [31:0]                      t_frac;
  logic [6:0]                       pp_shift;
  logic [wsea_pkg::ACC_W-1:0]       acc_add;
  logic                             term_sat, acc_ovf, acc_hold;
  logic [wsea_pkg::SUM_W:0]         sum64;
  logic [wsea_pkg::SUM_W-1:0]       new_sum;

  always_comb begin
    idx     = prod[32 +: wsea_pkg::TAB_AW];
    tab_lo  = wsea_pkg::POW2_TAB[idx];
    tab_hi  = wsea_pkg::POW2_TAB[wsea_pkg::TAB_AW'(idx + 1'b1)];
    pf      = wsea_pkg::PF_W'(lo_r + {1'b0, prod[63:32]});
    pos_shl = {15'd0, pf} << n_r[3:0];
    pos_val = pos_shl[wsea_pkg::PF_W+14:15];
    pos_sat = (n_r >= wsea_pkg::N_EXP_W'(16)) || pos_val[wsea_pkg::PF_W-1];
    neg_src = tz_r ? wsea_pkg::ONE_Q31[wsea_pkg::PF_W-1:0] : pf;
    neg_sh  = wsea_pkg::N_EXP_W'(15) + n_r;
    neg_val = neg_src >> neg_sh;
    t_frac  = prod[31:0];
    case (pp_cnt_r)
      2'd0:    pp_shift = 7'd0;
      2'd3:    pp_shift = 7'd64;
      default: pp_shift = 7'd32;
    endcase
    acc_add  = acc_r + (wsea_pkg::ACC_W'(prod) << pp_shift);
    term_sat = |acc_r[wsea_pkg::ACC_W-1:87];
    sum64    = {1'b0, error_sum_r} + {1'b0, acc_r[86:24]};
    acc_ovf  = term_sat || sum64[wsea_pkg::SUM_W];
    new_sum  = acc_ovf ? wsea_pkg::SUM_MAX : sum64[wsea_pkg::SUM_W-1:0];
    acc_hold = last_r && out_valid_r && !out_ch.ready;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wsea_pkg::ST_IDLE: if (in_ch.valid) state_nxt = wsea_pkg::ST_MAG;
      wsea_pkg::ST_MAG:  state_nxt = wsea_pkg::ST_NUM;
      wsea_pkg::ST_NUM:  state_nxt = wsea_pkg::ST_DIV;
      wsea_pkg::ST_DIV:  if (div_st.done) state_nxt = wsea_pkg::ST_LOG;
      wsea_pkg::ST_LOG:  state_nxt = wsea_pkg::ST_FRAC;
      wsea_pkg::ST_FRAC: state_nxt = wsea_pkg::ST_TMUL;
      wsea_pkg::ST_TMUL: state_nxt = wsea_pkg::ST_IDX;
      wsea_pkg::ST_IDX:  state_nxt = wsea_pkg::ST_SPAN;
      wsea_pkg::ST_SPAN: state_nxt = wsea_pkg::ST_POW;
      wsea_pkg::ST_POW:  state_nxt = wsea_pkg::ST_SQ;
      wsea_pkg::ST_SQ:   state_nxt = wsea_pkg::ST_GW;
      wsea_pkg::ST_GW:   state_nxt = wsea_pkg::ST_GWL;
      wsea_pkg::ST_GWL:  state_nxt = wsea_pkg::ST_PPI;
      wsea_pkg::ST_PPI:  state_nxt = wsea_pkg::ST_PPA;
      wsea_pkg::ST_PPA: begin
        state_nxt = (pp_cnt_r == 2'd3) ? wsea_pkg::ST_ACC : wsea_pkg::ST_PPI;
      end
      wsea_pkg::ST_ACC:  if (!acc_hold) state_nxt = wsea_pkg::ST_IDLE;
      default:           state_nxt = wsea_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier operands, divider start, ready
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    in_ready  = 1'b0;
    unique case (state_r)
      wsea_pkg::ST_IDLE: in_ready = 1'b1;
      wsea_pkg::ST_MAG: begin
        mul_a = {16'd0, k_mag};
        mul_b = d_r;
      end
      wsea_pkg::ST_NUM:  div_start = 1'b1;
      wsea_pkg::ST_LOG: begin
        mul_a = {10'd0, e_r};
        mul_b = {15'd0, wsea_pkg::LOG2E_Q16};
      end
      wsea_pkg::ST_TMUL: begin
        mul_a = targ_r;
        mul_b = wsea_pkg::MUL_W'(wsea_pkg::EXP_TABLE_ENTRIES);
      end
      wsea_pkg::ST_SPAN: begin
        mul_a = span_r;
        mul_b = rem_r;
      end
      wsea_pkg::ST_SQ: begin
        mul_a = ad_r;
        mul_b = ad_r;
      end
      wsea_pkg::ST_GW: begin
        mul_a = {16'd0, gain_r};
        mul_b = w_r;
      end
      wsea_pkg::ST_PPI: begin
        mul_a = pp_cnt_r[1] ? {16'd0, gw_r[47:32]} : gw_r[31:0];
        mul_b = pp_cnt_r[0] ? sq_r[63:32] : sq_r[31:0];
      end
      default: ;
    endcase
  end

  assign in_ch.ready = in_ready;

  // State and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wsea_pkg::ST_IDLE;
      clip_level_r <= wsea_pkg::CLIP_LEVEL_RESET;
      exp_gain_r   <= wsea_pkg::EXP_GAIN_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          wsea_pkg::CFG_CLIP_LEVEL: clip_level_r <= cfg_data;
          wsea_pkg::CFG_EXP_GAIN:   exp_gain_r   <= cfg_data[wsea_pkg::K_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      wsea_pkg::ST_IDLE: begin
        d_r    <= d33[31:0];
        ad_r   <= ad33[31:0];
        gain_r <= in_ch.curve_gain;
        last_r <= in_ch.last_point;
      end
      wsea_pkg::ST_DIV: begin
        e_r <= (div_st.ovf || div_q > wsea_pkg::EXP_CLAMP) ? wsea_pkg::EXP_CLAMP : div_q;
      end
      wsea_pkg::ST_FRAC: begin
        tz_r <= (t_frac == '0);
        if (k_neg && t_frac != '0) begin
          targ_r <= ~t_frac + 1'b1;
          n_r    <= prod[38:32] + 1'b1;
        end else begin
          targ_r <= t_frac;
          n_r    <= prod[38:32];
        end
      end
      wsea_pkg::ST_IDX: begin
        lo_r   <= tab_lo;
        span_r <= (tab_hi > tab_lo) ? 32'(tab_hi - tab_lo) : 32'd0;
        rem_r  <= prod[31:0];
      end
      wsea_pkg::ST_POW: begin
        if (k_neg) begin
          w_r      <= neg_val[31:0];
          sat_pt_r <= 1'b0;
        end else begin
          w_r      <= pos_sat ? 32'hFFFF_FFFF : pos_val[31:0];
          sat_pt_r <= pos_sat;
        end
      end
      wsea_pkg::ST_GW:  sq_r <= prod;
      wsea_pkg::ST_GWL: begin
        gw_r     <= prod[47:0];
        acc_r    <= '0;
        pp_cnt_r <= 2'd0;
      end
      wsea_pkg::ST_PPA: begin
        acc_r    <= acc_add;
        pp_cnt_r <= pp_cnt_r + 1'b1;
      end
      default: ;
    endcase
  end

  // Accumulate the point, load the result beat, release it when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == wsea_pkg::ST_ACC && !acc_hold && last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == wsea_pkg::ST_ACC && !acc_hold) begin
        if (last_r) begin
          out_total_r <= new_sum;
          out_sat_r   <= overflow_r || sat_pt_r || acc_ovf;
          error_sum_r <= '0;
          overflow_r  <= 1'b0;
        end else begin
          error_sum_r <= new_sum;
          overflow_r  <= overflow_r || sat_pt_r || acc_ovf;
        end
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.total_error = out_total_r;
  assign out_ch.saturated   = out_sat_r;

  // Checks
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> state_r == wsea_pkg::ST_MAG)
    else $error("accepted point did not start the sequence");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> state_r == wsea_pkg::ST_DIV)
    else $error("divider finished outside its wait state");

  a_last_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wsea_pkg::ST_ACC && last_r && !acc_hold) |=> out_valid_r)
    else $error("last point did not load a result beat");

  a_last_clears_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wsea_pkg::ST_ACC && last_r && !acc_hold) |=>
      (error_sum_r == '0 && !overflow_r))
    else $error("total not cleared after last point");

endmodule

@@ hdl/wsea_mul.sv @@
// ----------------------------------------------------------------------------
// wsea_mul: shared 32x32 multiplier
// Unsigned product with a registered output.
// ----------------------------------------------------------------------------
module wsea_mul (
  input  logic                          clk,
  input  logic [wsea_pkg::MUL_W-1:0]    op_a,
  input  logic [wsea_pkg::MUL_W-1:0]    op_b,
  output logic [wsea_pkg::PROD_W-1:0]   prod
);

  logic [wsea_pkg::PROD_W-1:0] prod_r;

  // Register the product
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

@@ hdl/wsea_div.sv @@
// ----------------------------------------------------------------------------
// wsea_div: restoring divider for the exponent
// One quotient bit a cycle; flags quotients that do not fit in Q_W bits.
// ----------------------------------------------------------------------------
module wsea_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wsea_pkg::NUM_W-1:0]    num,
  input  logic [wsea_pkg::MAX_W-1:0]    den,
  output wsea_pkg::div_status_t         status,
  output logic [wsea_pkg::Q_W-1:0]      quot
);

  localparam int HI_W = wsea_pkg::NUM_W - wsea_pkg::Q_W;

  logic                          busy_r;
  logic                          done_r;
  logic                          ovf_r;
  logic [wsea_pkg::CNT_W-1:0]    cnt_r;
  logic [wsea_pkg::MAX_W-1:0]    rem_r;
  logic [wsea_pkg::MAX_W-1:0]    den_r;
  logic [wsea_pkg::Q_W-1:0]      low_r;
  logic [wsea_pkg::Q_W-1:0]      q_r;

  logic [wsea_pkg::MAX_W:0]      rem2;
  logic [wsea_pkg::MAX_W:0]      rem_sub;
  logic                          rem_ge;
  logic                          too_big;

  // One restoring step
  always_comb begin
    rem2    = {rem_r, low_r[wsea_pkg::Q_W-1]};
    rem_ge  = rem2 >= {1'b0, den_r};
    rem_sub = rem2 - {1'b0, den_r};
    too_big = num[wsea_pkg::NUM_W-1:wsea_pkg::Q_W] >= HI_W'(den);
  end

  // Load, iterate, flag done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ovf_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        den_r <= den;
        ovf_r <= too_big;
        cnt_r <= '0;
        rem_r <= num[wsea_pkg::Q_W +: wsea_pkg::MAX_W];
        low_r <= num[wsea_pkg::Q_W-1:0];
        if (too_big) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= rem_ge ? rem_sub[wsea_pkg::MAX_W-1:0] : rem2[wsea_pkg::MAX_W-1:0];
        low_r <= {low_r[wsea_pkg::Q_W-2:0], 1'b0};
        q_r   <= {q_r[wsea_pkg::Q_W-2:0], rem_ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == wsea_pkg::CNT_W'(wsea_pkg::Q_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign status.done = done_r;
  assign status.ovf  = ovf_r;
  assign quot        = q_r;

endmodule
